// ===== hw/rtl/pfp_pkg.sv =====
package pfp_pkg;

  localparam logic [7:0] StartByte     = 8'h42;
  localparam int         FrameBytes    = 32;
  localparam int         SummedBytes   = 30;
  localparam int         FrameWords    = 15;
  localparam int         MeasCount     = 12;
  localparam int         MeasFirstByte = 4;

  localparam int PosW = $clog2(FrameBytes);
  localparam int IdxW = 4;

  localparam logic [PosW-1:0] PosLastSummed = PosW'(SummedBytes - 1);
  localparam logic [PosW-1:0] PosCksHigh    = PosW'(SummedBytes);
  localparam logic [PosW-1:0] PosCksLow     = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosMeasLow    = PosW'(MeasFirstByte + 1);
  localparam logic [PosW-1:0] PosMeasEnd    = PosW'(MeasFirstByte + 2 * MeasCount);
  localparam logic [IdxW-1:0] IdxLast       = IdxW'(MeasCount - 1);

  // byte 2 starts the first frame word; bytes 4..27 hold the measurements
  localparam int FirstWordByte = 2;
  localparam int MeasWordCount = FrameWords - 3;

  typedef logic [15:0] pfp_word_t;
  typedef logic [MeasCount-1:0][15:0] pfp_words_t;

  typedef struct packed {
    logic load;
    logic ok;
  } pfp_load_t;

endpackage

// ===== hw/rtl/pfp_emitter.sv =====
module pfp_emitter
  import pfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfp_load_t             load_i,
  input  pfp_words_t            words_i,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdxW-1:0]       word_index_o,
  output logic [15:0]           word_value_o,
  output logic                  frame_ok_o,
  output logic                  last_o
);

  logic            valid_q, valid_d;
  logic            ok_q, ok_d;
  logic [IdxW-1:0] idx_q, idx_d;
  pfp_words_t      buf_q;
  logic            out_acc;

  assign out_acc = valid_q && !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    ok_d    = ok_q;
    idx_d   = idx_q;
    if (out_acc) begin
      if (last_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (load_i.load) begin
      valid_d = 1'b1;
      ok_d    = load_i.ok;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ok_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ok_q    <= ok_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      buf_q <= words_i;
    end
  end

  assign busy_o       = valid_q;
  assign out_valid_o  = valid_q;
  assign frame_ok_o   = ok_q;
  assign word_index_o = ok_q ? idx_q : '0;
  assign word_value_o = ok_q ? buf_q[idx_q] : 16'h0000;
  assign last_o       = !ok_q || (idx_q == IdxLast);

endmodule

// ===== hw/rtl/particle_sensor_frame_parser.sv =====
// Frame parser for a particulate sensor's 32-byte serial frames.
// Input channel: one received byte per item on rx_byte_i, taken when
// in_valid_i is high and in_stall_o is low. Bytes are dropped until a 0x42
// start byte opens a frame; the frame's 30 leading bytes are summed mod 2^16
// and checked against the big-endian checksum in bytes 30 and 31.
// Output channel: on a good frame, twelve items (word_index 0..11 with the
// measurement word, frame_ok high, last on index 11); on a bad checksum one
// item with frame_ok low, last high, index and value zero.
// Throughput: one byte per cycle while in_stall_o is low. The first result
// is valid the cycle after the last frame byte is taken; results drain at one
// per cycle while out_stall_i is low, from a twelve-word output buffer while
// the next frame is already being parsed.
// Stall: out_stall_i holds the current result. Input stalls only on a frame's
// final byte while the previous frame's results are still in the buffer.
// Reset: asynchronous, active low; hunting for a start byte, no result held.
module particle_sensor_frame_parser
  import pfp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] word_index_o,
  output logic [15:0]     word_value_o,
  output logic            frame_ok_o,
  output logic            last_o
);

  logic            in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      hold_q;
  logic [7:0]      cks_hi_q;
  pfp_words_t      store_q;

  logic            accept;
  logic            frame_end;
  logic            busy;
  logic            meas_wr;
  logic [PosW-1:0] meas_off;
  logic [IdxW-1:0] meas_k;
  pfp_load_t       load;

  assign frame_end  = in_frame_q && (pos_q == PosCksLow);
  assign in_stall_o = frame_end && busy;
  assign accept     = in_valid_i && !in_stall_o;

  assign meas_wr  = in_frame_q && pos_q[0] && (pos_q >= PosMeasLow) && (pos_q < PosMeasEnd);
  assign meas_off = pos_q - PosMeasLow;
  assign meas_k   = IdxW'(meas_off >> 1);

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    if (!in_frame_q) begin
      if (rx_byte_i == StartByte) begin
        in_frame_d = 1'b1;
        pos_d      = PosW'(1);
        sum_d      = {8'h00, rx_byte_i};
      end
    end else if (frame_end) begin
      in_frame_d = 1'b0;
      pos_d      = '0;
    end else begin
      pos_d = pos_q + PosW'(1);
      if (pos_q <= PosLastSummed) begin
        sum_d = sum_q + {8'h00, rx_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
      hold_q     <= '0;
      cks_hi_q   <= '0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      if (in_frame_q && !pos_q[0] && (pos_q <= PosLastSummed)) begin
        hold_q <= rx_byte_i;
      end
      if (in_frame_q && (pos_q == PosCksHigh)) begin
        cks_hi_q <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && meas_wr) begin
      store_q[meas_k] <= {hold_q, rx_byte_i};
    end
  end

  assign load.load = accept && frame_end;
  assign load.ok   = ({cks_hi_q, rx_byte_i} == sum_q);

  pfp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .words_i      (store_q),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .frame_ok_o   (frame_ok_o),
    .last_o       (last_o)
  );

endmodule

// ===== tb/sv/particle_sensor_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module particle_sensor_frame_parser_tb
  import pfp_pkg::*;
;

  localparam int RandomBytes   = 220;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 16;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [15:0]     value;
    logic            ok;
    logic            last;
  } pm_result_t;

  class pm_frame_tracker;
    bit                in_frame;
    bit [PosW-1:0]     pos;
    bit [15:0]         sum;
    bit [7:0]          hi_hold;
    bit [7:0]          cks_hi;
    bit [15:0]         meas [MeasCount];
    pm_result_t        due_words[$];
    int unsigned       mismatches;

    function void take_byte(bit [7:0] b);
      bit [15:0]  cks;
      pm_result_t r;
      int         n;
      if (!in_frame) begin
        if (b == StartByte) begin
          in_frame = 1'b1;
          pos      = PosW'(1);
          sum      = 16'(b);
        end
      end else if (pos <= PosLastSummed) begin
        sum = sum + 16'(b);
        if (!pos[0]) begin
          hi_hold = b;
        end else if (pos >= PosMeasLow && pos < PosMeasEnd) begin
          meas[IdxW'((pos - PosMeasLow) >> 1)] = {hi_hold, b};
        end
        pos = pos + PosW'(1);
      end else if (pos == PosCksHigh) begin
        cks_hi = b;
        pos    = pos + PosW'(1);
      end else begin
        cks      = {cks_hi, b};
        in_frame = 1'b0;
        pos      = '0;
        if (cks != sum) begin
          r.index = '0;
          r.value = '0;
          r.ok    = 1'b0;
          r.last  = 1'b1;
          due_words.push_back(r);
        end else begin
          for (n = 0; n < MeasCount; n++) begin
            r.index = IdxW'(n);
            r.value = meas[n];
            r.ok    = 1'b1;
            r.last  = (n == MeasCount - 1);
            due_words.push_back(r);
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(pm_result_t got);
      pm_result_t want;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected item index %0h value %0h ok %0b last %0b",
                 $time, got.index, got.value, got.ok, got.last);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      compare_field("word_index", 16'(want.index), 16'(got.index));
      compare_field("word_value", want.value, got.value);
      compare_field("frame_ok", 16'(want.ok), 16'(got.ok));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [7:0]      rx_byte;
  logic            out_valid;
  logic            out_stall;
  logic [IdxW-1:0] word_index;
  logic [15:0]     word_value;
  logic            frame_ok;
  logic            last;

  pm_frame_tracker tracker = new;

  int burst_left;
  int random_sent;
  int stall_mode;
  int stall_mode_left;

  particle_sensor_frame_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .word_index_o (word_index),
    .word_value_o (word_value),
    .frame_ok_o   (frame_ok),
    .last_o       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: switches among no stall, light and heavy stalling
  initial begin
    out_stall       = 1'b0;
    stall_mode      = 0;
    stall_mode_left = 0;
    forever begin
      @(negedge clk);
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(20, 120);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_word('{word_index, word_value, frame_ok, last});
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 48);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    burst_left--;
  endtask

  // style: 0 random, 1 all ones, 2 all zeros, 3 mix of extremes and start bytes
  task automatic send_frame(input bit good, input int style);
    logic [7:0] frame [FrameBytes];
    logic [15:0] sum;
    int i;
    sum      = '0;
    frame[0] = StartByte;
    frame[1] = ($urandom_range(0, 1) == 0) ? 8'h4d : 8'($urandom);
    for (i = FirstWordByte; i < SummedBytes; i++) begin
      case (style)
        1: frame[i] = 8'hff;
        2: frame[i] = 8'h00;
        3: begin
          case ($urandom_range(0, 3))
            0: frame[i] = 8'h00;
            1: frame[i] = 8'hff;
            2: frame[i] = StartByte;
            default: frame[i] = 8'($urandom);
          endcase
        end
        default: frame[i] = 8'($urandom);
      endcase
    end
    for (i = 0; i < SummedBytes; i++) begin
      sum = sum + 16'(frame[i]);
    end
    if (!good) begin
      sum = sum ^ 16'($urandom_range(1, 65535));
    end
    frame[SummedBytes]     = sum[15:8];
    frame[SummedBytes + 1] = sum[7:0];
    for (i = 0; i < FrameBytes; i++) begin
      push_byte(frame[i]);
    end
  endtask

  initial begin
    int pick;
    int n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    burst_left  = 0;
    random_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle noise, then frames at the field extremes, a bad checksum and
    // start bytes inside a frame
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h41);
    push_byte(8'h43);
    send_frame(1'b1, 1);
    send_frame(1'b1, 2);
    send_frame(1'b0, 0);
    send_frame(1'b1, 3);

    while (random_sent < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(1'b1, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        random_sent += FrameBytes;
      end else if (pick < 85) begin
        send_frame(1'b0, $urandom_range(0, 3));
        random_sent += FrameBytes;
      end else if (pick < 95) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom));
        random_sent += n;
      end else begin
        // stray start byte: misaligns the following frame
        n = $urandom_range(1, 20);
        push_byte(StartByte);
        repeat (n) push_byte(8'($urandom));
        random_sent += n + 1;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_emitter.sv
hw/rtl/particle_sensor_frame_parser.sv
tb/sv/particle_sensor_frame_parser_tb.sv
